// ----- hdl/gdsc_pkg.sv -----
// Shared types, constants and an arithmetic helper for the glyph drop shadow compositor.
package gdsc_pkg;

  localparam int MAX_GLYPH_WIDTH  = 1024;
  localparam int MAX_GLYPH_HEIGHT = 256;
  localparam int ROW_DEPTH        = MAX_GLYPH_WIDTH + 2;

  localparam int COL_W   = 11;
  localparam int ROW_W   = 9;
  localparam int ADDR_W  = $clog2(ROW_DEPTH);
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [COL_W-1:0] MAX_W_VAL = COL_W'(MAX_GLYPH_WIDTH);
  localparam logic [ROW_W-1:0] MAX_H_VAL = ROW_W'(MAX_GLYPH_HEIGHT);

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RED    = 3'd2,
    REG_GREEN  = 3'd3,
    REG_BLUE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] glyph_width;
    logic [ROW_W-1:0] glyph_height;
    logic [7:0]       font_red;
    logic [7:0]       font_green;
    logic [7:0]       font_blue;
  } cfg_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] shadow;
    logic       last;
  } slot_t;

  // Exact floor(p / 255) for any product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- hdl/gdsc_regs.sv -----
// Configuration register file with an APB-style write and read port.
module gdsc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gdsc_pkg::PADDR_W-1:0]   paddr,
  input  logic [gdsc_pkg::PDATA_W-1:0]   pwdata,
  output logic [gdsc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output gdsc_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width  <= gdsc_pkg::COL_W'(1);
      cfg.glyph_height <= gdsc_pkg::ROW_W'(1);
      cfg.font_red     <= 8'd0;
      cfg.font_green   <= 8'd0;
      cfg.font_blue    <= 8'd0;
    end else if (wr_en) begin
      case (idx)
        gdsc_pkg::REG_WIDTH:  cfg.glyph_width  <= pwdata[gdsc_pkg::COL_W-1:0];
        gdsc_pkg::REG_HEIGHT: cfg.glyph_height <= pwdata[gdsc_pkg::ROW_W-1:0];
        gdsc_pkg::REG_RED:    cfg.font_red     <= pwdata[7:0];
        gdsc_pkg::REG_GREEN:  cfg.font_green   <= pwdata[7:0];
        gdsc_pkg::REG_BLUE:   cfg.font_blue    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gdsc_pkg::REG_WIDTH:  prdata = gdsc_pkg::PDATA_W'(cfg.glyph_width);
      gdsc_pkg::REG_HEIGHT: prdata = gdsc_pkg::PDATA_W'(cfg.glyph_height);
      gdsc_pkg::REG_RED:    prdata = gdsc_pkg::PDATA_W'(cfg.font_red);
      gdsc_pkg::REG_GREEN:  prdata = gdsc_pkg::PDATA_W'(cfg.font_green);
      gdsc_pkg::REG_BLUE:   prdata = gdsc_pkg::PDATA_W'(cfg.font_blue);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- hdl/gdsc_front.sv -----
// Front end: frame position counters, row store and classification of each slot.
module gdsc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  gdsc_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            coverage,
  output logic                  push,
  output gdsc_pkg::slot_t       push_slot,
  input  logic                  push_ready
);

  localparam int COL_W  = gdsc_pkg::COL_W;
  localparam int ROW_W  = gdsc_pkg::ROW_W;
  localparam int ADDR_W = gdsc_pkg::ADDR_W;

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [7:0]       held_shadow_sample;
  logic [7:0]       row_store [gdsc_pkg::ROW_DEPTH];

  logic [COL_W-1:0] w;
  logic [ROW_W-1:0] h;
  logic             accept;
  logic             interior;
  logic             row_end;
  logic             col_last;
  logic             last;
  logic [7:0]       g;
  logic [ADDR_W-1:0] addr;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign addr     = ADDR_W'(column_count);

  always_comb begin
    if (cfg.glyph_width == '0) begin
      w = COL_W'(1);
    end else if (cfg.glyph_width > gdsc_pkg::MAX_W_VAL) begin
      w = gdsc_pkg::MAX_W_VAL;
    end else begin
      w = cfg.glyph_width;
    end
    if (cfg.glyph_height == '0) begin
      h = ROW_W'(1);
    end else if (cfg.glyph_height > gdsc_pkg::MAX_H_VAL) begin
      h = gdsc_pkg::MAX_H_VAL;
    end else begin
      h = cfg.glyph_height;
    end
  end

  always_comb begin
    interior = (column_count >= COL_W'(1)) && (column_count <= w) &&
               (row_count >= ROW_W'(1)) && (row_count <= h);
    g        = interior ? coverage : 8'd0;
    row_end  = {1'b0, column_count} >= ({1'b0, w} + (COL_W+1)'(1));
    col_last = {1'b0, row_count} >= ({1'b0, h} + (ROW_W+1)'(1));
    last     = row_end && col_last;
    push_slot.glyph  = g;
    push_slot.shadow = ((column_count >= COL_W'(2)) && (row_count >= ROW_W'(2))) ?
                       held_shadow_sample : 8'd0;
    push_slot.last   = last;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = col_last ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count_next = column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_shadow_sample <= 8'd0;
    end else if (accept) begin
      held_shadow_sample <= row_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[addr] <= g;
    end
  end

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    column_count <= COL_W'(gdsc_pkg::MAX_GLYPH_WIDTH + 1))
    else $error("column count left the padded frame");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= ROW_W'(gdsc_pkg::MAX_GLYPH_HEIGHT + 1))
    else $error("row count left the padded frame");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap after the last word of a frame");

endmodule

// ----- hdl/gdsc_queue.sv -----
// Two-entry queue of classified slots between the front and back ends.
module gdsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gdsc_pkg::slot_t  push_slot,
  output logic             push_ready,
  output logic             pop_valid,
  output gdsc_pkg::slot_t  pop_slot,
  input  logic             pop_ready
);

  gdsc_pkg::slot_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_slot   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (do_pop && !do_push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_slot;
    end
  end

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with the fill count");

endmodule

// ----- hdl/gdsc_back.sv -----
// Back end: shadow and glyph compositing into the registered output word.
module gdsc_back (
  input  logic             clk,
  input  logic             rst,
  input  gdsc_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  gdsc_pkg::slot_t  in_slot,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_data,
  output logic             out_last
);

  logic [7:0]  g, s;
  logic [7:0]  b, gr, r, a;
  logic [15:0] pb, pg, pr, pa;
  logic        load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;
  assign g        = in_slot.glyph;
  assign s        = in_slot.shadow;

  always_comb begin
    pb = 16'(cfg.font_blue) * 16'(g);
    pg = 16'(cfg.font_green) * 16'(g);
    pr = 16'(cfg.font_red) * 16'(g);
    pa = 16'(8'd255 - g) * 16'(s);
    if (g == 8'd0) begin
      if (s == 8'd0) begin
        b = cfg.font_blue;  gr = cfg.font_green;  r = cfg.font_red;  a = 8'd0;
      end else begin
        b = 8'd0;  gr = 8'd0;  r = 8'd0;  a = s;
      end
    end else if (s == 8'd0) begin
      b = cfg.font_blue;  gr = cfg.font_green;  r = cfg.font_red;  a = g;
    end else begin
      b  = gdsc_pkg::div255(pb);
      gr = gdsc_pkg::div255(pg);
      r  = gdsc_pkg::div255(pr);
      a  = 8'(g + gdsc_pkg::div255(pa));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {a, r, gr, b};
      out_last <= in_slot.last;
    end
  end

endmodule

// ----- hdl/glyph_drop_shadow_compositor.sv -----
// Top level of the glyph drop shadow compositor.
//
//   channel   direction  handshake               payload
//   config    in         psel/penable/pwrite     paddr, pwdata, prdata
//   slot in   in         s_tvalid/s_tready       s_tdata: coverage
//   pixel out out        m_tvalid/m_tready       m_tdata: blue, green, red, alpha; m_tlast
//
// One word is accepted and one pixel delivered per cycle when the output is not stalled.
// An accepted slot passes through the queue register and then the output register on its way
// to m_tdata; the compositing multiply sits between them.
// Reset clears the position counters, the held shadow sample, the queue and the output.
// The two-entry queue lets s_tready stay high while one finished pixel waits on m_tready, until both entries fill.
module glyph_drop_shadow_compositor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gdsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [gdsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [gdsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // coverage
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // blue, green, red, alpha
  output logic                          m_tlast    // frame_end
);

  gdsc_pkg::cfg_t  cfg;
  gdsc_pkg::slot_t push_slot, pop_slot;
  logic            push, push_ready, pop_valid, pop_ready;

  gdsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gdsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .coverage   (s_tdata),
    .push       (push),
    .push_slot  (push_slot),
    .push_ready (push_ready)
  );

  gdsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_slot  (push_slot),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_slot   (pop_slot),
    .pop_ready  (pop_ready)
  );

  gdsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_slot   (pop_slot),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
